### rtl/core/ahosc_pkg.sv
// ----------------------------------------------------------------------------
// ahosc_pkg
// Shared types, constants and the quarter-wave sine builder for the
// additive harmonic oscillator.
// ----------------------------------------------------------------------------
package ahosc_pkg;

	// default sizing
	localparam int MAX_HARMONICS   = 8;
	localparam int SINE_TABLE_BITS = 12;
	localparam int PHASE_BITS      = 32;

	// register reset values
	localparam logic [16:0] SAMPLE_RATE_RST = 17'd44100;
	localparam logic [14:0] TONE_FREQ_RST   = 15'd440;
	localparam logic [14:0] AMPLITUDE_RST   = 15'd3277;

	// accumulator width, Q37 with headroom for nine partials
	localparam int ACC_W = 44;

	// pi in Q30
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// register map, index = paddr / 8
	typedef enum logic [2:0] {
		REG_SAMPLE_RATE = 3'd0,
		REG_TONE_FREQ   = 3'd1,
		REG_AMPLITUDE   = 3'd2,
		REG_HARM_COUNT  = 3'd3,
		REG_HARM_WEIGHT = 3'd4,
		REG_VIB_ON      = 3'd5,
		REG_VIB_DEPTH   = 3'd6,
		REG_VIB_RATE    = 3'd7
	} reg_idx_t;

	// configuration bundle from the register file
	typedef struct packed {
		logic [16:0] sample_rate;
		logic [14:0] tone_frequency;
		logic [14:0] amplitude;
		logic [3:0]  harmonic_count;
		logic [63:0] harmonic_weights;
		logic        vibrato_on;
		logic [9:0]  vibrato_depth_hz;
		logic [6:0]  vibrato_rate_hz;
	} cfg_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_F_ADDR,
		ST_F_MUL,
		ST_F_ACC,
		ST_H_MUL,
		ST_H_HF,
		ST_H_HF_W,
		ST_H_PH_W,
		ST_H_ADDR,
		ST_H_MULW,
		ST_H_MULS,
		ST_H_HDIV,
		ST_H_HDIV_W,
		ST_H_UPD,
		ST_V_ADDR,
		ST_V_MUL,
		ST_V_FREQ,
		ST_V_FDIV_W,
		ST_V_VDIV_W,
		ST_WRAP,
		ST_OUT
	} state_t;

	// one taylor step: t * x^2 in Q30
	function automatic longint unsigned taylor_step(longint unsigned t, longint unsigned x);
		longint unsigned r;
		r = (t * x) >> 30;
		r = (r * x) >> 30;
		return r;
	endfunction

	// Q15 sine of quarter-wave position q, evaluated at elaboration
	function automatic logic [14:0] quarter_sine(int unsigned q, int tb);
		longint unsigned x;
		longint unsigned t;
		longint unsigned r;
		longint          s;
		x = ((longint'(q) * 64'd2 * PI_Q30) + (64'd1 << (tb - 1))) >> tb;
		t = x;
		s = longint'(x);
		t = taylor_step(t, x) / 64'd6;
		s = s - longint'(t);
		t = taylor_step(t, x) / 64'd20;
		s = s + longint'(t);
		t = taylor_step(t, x) / 64'd42;
		s = s - longint'(t);
		t = taylor_step(t, x) / 64'd72;
		s = s + longint'(t);
		t = taylor_step(t, x) / 64'd110;
		s = s - longint'(t);
		t = taylor_step(t, x) / 64'd156;
		s = s + longint'(t);
		if (s < 0) begin
			s = 0;
		end
		r = ((longint'(s) * 64'd32767) + (64'd1 << 29)) >> 30;
		return r[14:0];
	endfunction

endpackage

### rtl/core/ahosc_sine_rom.sv
// ----------------------------------------------------------------------------
// ahosc_sine_rom
// Quarter-wave sine ROM with registered read; returns magnitude and sign.
// ----------------------------------------------------------------------------
module ahosc_sine_rom #(
	parameter int TB = ahosc_pkg::SINE_TABLE_BITS
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [TB-1:0] phase_idx,
	output logic [14:0]   mag_q,
	output logic          neg_q
);

	localparam int QLEN = (1 << (TB - 2)) + 1;

	typedef logic [14:0] qwave_t [QLEN];

	function automatic qwave_t build_qwave();
		qwave_t w;
		for (int i = 0; i < QLEN; i++) begin
			w[i] = ahosc_pkg::quarter_sine(i, TB);
		end
		return w;
	endfunction

	localparam qwave_t QWAVE = build_qwave();

	logic [1:0]    quad;
	logic [TB-1:0] low;
	logic [TB-2:0] addr;

	// fold the full-wave index onto the quarter wave
	always_comb begin
		quad = phase_idx[TB-1:TB-2];
		low  = phase_idx;
		low[TB-1:TB-2] = 2'b00;
		if (quad[0]) begin
			addr = (TB-1)'((1 << (TB - 2)) - int'(low));
		end else begin
			addr = low[TB-2:0];
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mag_q <= QWAVE[addr];
			neg_q <= quad[1];
		end
	end

endmodule

### rtl/core/ahosc_div.sv
// ----------------------------------------------------------------------------
// ahosc_div
// Shared restoring divider, one quotient bit per cycle; also keeps the
// remainder of the dividend's upper field.
// ----------------------------------------------------------------------------
module ahosc_div #(
	parameter int PB  = ahosc_pkg::PHASE_BITS,
	parameter int DVW = PB + 17
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVW-1:0] dividend,
	input  logic [16:0]    divisor,
	output logic           busy,
	output logic           done,
	output logic [DVW-1:0] quotient,
	output logic [16:0]    remainder,
	output logic [16:0]    mid_rem
);

	localparam int CW = $clog2(DVW + 1);

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [DVW-1:0] work_q;
	logic [16:0]    rem_q;
	logic [16:0]    dvs_q;
	logic [16:0]    mid_q;
	logic [17:0]    trial;
	logic           ge;
	logic [16:0]    rem_nxt;

	// one restoring step
	always_comb begin
		trial   = {rem_q, work_q[DVW-1]};
		ge      = trial >= {1'b0, dvs_q};
		rem_nxt = ge ? 17'(trial - {1'b0, dvs_q}) : trial[16:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DVW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
			busy_q <= (cnt_q != CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DVW-2:0], ge};
			rem_q  <= rem_nxt;
			if (cnt_q == CW'(PB + 1)) begin
				mid_q <= rem_nxt;
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;
	assign mid_rem   = mid_q;

endmodule

### rtl/core/ahosc_engine.sv
// ----------------------------------------------------------------------------
// ahosc_engine
// Sample sequencer: walks the fundamental, harmonics and phase updates
// through one shared divider, one multiplier and the sine ROM.
// ----------------------------------------------------------------------------
module ahosc_engine #(
	parameter int MAXH = ahosc_pkg::MAX_HARMONICS,
	parameter int TB   = ahosc_pkg::SINE_TABLE_BITS,
	parameter int PB   = ahosc_pkg::PHASE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ahosc_pkg::cfg_t    cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample_out,
	output logic               clipped
);

	localparam int DVW = PB + 17;
	localparam int HIW = (MAXH > 1) ? $clog2(MAXH) : 1;
	localparam int AW  = ahosc_pkg::ACC_W;

	ahosc_pkg::state_t state_q, state_d;

	// model state
	logic [16:0]   idx_q;
	logic [PB-1:0] fph_q;
	logic [PB-1:0] vph_q;
	logic [16:0]   hn_q [MAXH];

	// working registers
	logic            rst_req_q;
	logic [HIW-1:0]  h_q;
	logic [PB-1:0]   hph_q;
	logic [AW-1:0]   acc_q;
	logic [37:0]     prod_q;
	logic            sign_q;
	logic            active_q;
	logic            fneg_q;
	logic [16:0]     hfmod_q;
	logic [16:0]     numrem_q;
	logic            out_valid_q;
	logic [15:0]     sample_q;
	logic            clipped_q;

	// shared unit hookup
	logic           div_start;
	logic [DVW-1:0] div_dividend;
	logic [16:0]    div_divisor;
	logic           div_busy;
	logic           div_done;
	logic [DVW-1:0] div_quot;
	logic [16:0]    div_rem;
	logic [16:0]    div_mid;
	logic           rom_en;
	logic [TB-1:0]  rom_idx;
	logic [14:0]    rom_mag;
	logic           rom_neg;
	logic           mul_en;
	logic [22:0]    mul_a;
	logic [14:0]    mul_b;

	// derived values
	logic [16:0]   sr_eff;
	logic [3:0]    hnum;
	logic          last_h;
	logic [7:0]    weight;
	logic [31:0]   fbase;
	logic [31:0]   freq;
	logic          fneg;
	logic [30:0]   fmag;
	logic [16:0]   idx_inc;
	logic          clr_start;
	logic          clr_wrap;
	logic [17:0]   num_sum;
	logic [AW-1:0] fund_term;
	logic [AW-1:0] harm_term;
	logic [AW-1:0] rnd;
	logic [21:0]   res;
	logic          slot_free;
	logic          accept;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		sr_eff    = (cfg.sample_rate == 17'd0) ? 17'd1 : cfg.sample_rate;
		hnum      = 4'(h_q) + 4'd1;
		last_h    = (h_q == HIW'(MAXH - 1));
		weight    = cfg.harmonic_weights[{h_q, 3'b000} +: 8];
		fbase     = {2'b00, cfg.tone_frequency, 15'd0};
		if (cfg.vibrato_on) begin
			freq = sign_q ? fbase - {7'd0, prod_q[24:0]} : fbase + {7'd0, prod_q[24:0]};
		end else begin
			freq = fbase;
		end
		fneg      = freq[31];
		fmag      = fneg ? 31'(-freq) : freq[30:0];
		idx_inc   = idx_q + 17'd1;
		clr_start = rst_req_q || (idx_q >= sr_eff);
		clr_wrap  = (idx_inc == 17'd0) || (idx_inc >= sr_eff);
		num_sum   = {1'b0, numrem_q} + {1'b0, hfmod_q};
		fund_term = {7'd0, prod_q[29:0], 7'd0};
		harm_term = AW'(div_quot[37:0]);
		rnd       = acc_q + (AW'(1) << 21);
		res       = rnd[AW-1:22];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ahosc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit controls
	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = sr_eff;
		rom_en       = 1'b0;
		rom_idx      = fph_q[PB-1 -: TB];
		mul_en       = 1'b0;
		mul_a        = 23'(cfg.amplitude);
		mul_b        = rom_mag;
		unique case (state_q)
			ahosc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ahosc_pkg::ST_CLEAR;
				end
			end
			ahosc_pkg::ST_CLEAR: begin
				state_d = ahosc_pkg::ST_F_ADDR;
			end
			ahosc_pkg::ST_F_ADDR: begin
				rom_en  = 1'b1;
				state_d = ahosc_pkg::ST_F_MUL;
			end
			ahosc_pkg::ST_F_MUL: begin
				mul_en  = 1'b1;
				state_d = ahosc_pkg::ST_F_ACC;
			end
			ahosc_pkg::ST_F_ACC: begin
				state_d = ahosc_pkg::ST_H_MUL;
			end
			ahosc_pkg::ST_H_MUL: begin
				mul_en  = 1'b1;
				mul_a   = 23'(cfg.tone_frequency);
				mul_b   = 15'(hnum);
				state_d = ahosc_pkg::ST_H_HF;
			end
			ahosc_pkg::ST_H_HF: begin
				div_start    = 1'b1;
				div_dividend = DVW'(prod_q[18:0]);
				state_d      = ahosc_pkg::ST_H_HF_W;
			end
			ahosc_pkg::ST_H_HF_W: begin
				div_dividend = {hn_q[h_q], {PB{1'b0}}};
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ahosc_pkg::ST_H_PH_W;
				end
			end
			ahosc_pkg::ST_H_PH_W: begin
				if (div_done) begin
					state_d = active_q ? ahosc_pkg::ST_H_ADDR : ahosc_pkg::ST_H_UPD;
				end
			end
			ahosc_pkg::ST_H_ADDR: begin
				rom_en  = 1'b1;
				rom_idx = hph_q[PB-1 -: TB];
				state_d = ahosc_pkg::ST_H_MULW;
			end
			ahosc_pkg::ST_H_MULW: begin
				mul_en  = 1'b1;
				mul_b   = 15'(weight);
				state_d = ahosc_pkg::ST_H_MULS;
			end
			ahosc_pkg::ST_H_MULS: begin
				mul_en  = 1'b1;
				mul_a   = prod_q[22:0];
				state_d = ahosc_pkg::ST_H_HDIV;
			end
			ahosc_pkg::ST_H_HDIV: begin
				div_start    = 1'b1;
				div_dividend = DVW'(prod_q);
				div_divisor  = 17'(hnum);
				state_d      = ahosc_pkg::ST_H_HDIV_W;
			end
			ahosc_pkg::ST_H_HDIV_W: begin
				if (div_done) begin
					state_d = ahosc_pkg::ST_H_UPD;
				end
			end
			ahosc_pkg::ST_H_UPD: begin
				state_d = last_h ? ahosc_pkg::ST_V_ADDR : ahosc_pkg::ST_H_MUL;
			end
			ahosc_pkg::ST_V_ADDR: begin
				rom_en  = 1'b1;
				rom_idx = vph_q[PB-1 -: TB];
				state_d = ahosc_pkg::ST_V_MUL;
			end
			ahosc_pkg::ST_V_MUL: begin
				mul_en  = 1'b1;
				mul_a   = 23'(cfg.vibrato_depth_hz);
				state_d = ahosc_pkg::ST_V_FREQ;
			end
			ahosc_pkg::ST_V_FREQ: begin
				div_start    = 1'b1;
				div_dividend = DVW'({fmag, {(PB - 15){1'b0}}});
				state_d      = ahosc_pkg::ST_V_FDIV_W;
			end
			ahosc_pkg::ST_V_FDIV_W: begin
				div_dividend = DVW'({cfg.vibrato_rate_hz, {PB{1'b0}}});
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ahosc_pkg::ST_V_VDIV_W;
				end
			end
			ahosc_pkg::ST_V_VDIV_W: begin
				if (div_done) begin
					state_d = ahosc_pkg::ST_WRAP;
				end
			end
			ahosc_pkg::ST_WRAP: begin
				state_d = ahosc_pkg::ST_OUT;
			end
			ahosc_pkg::ST_OUT: begin
				if (slot_free) begin
					state_d = ahosc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ahosc_pkg::ST_IDLE;
			end
		endcase
	end

	// index, phases and harmonic numerators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			fph_q <= '0;
			vph_q <= '0;
			for (int i = 0; i < MAXH; i++) begin
				hn_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ahosc_pkg::ST_CLEAR: begin
					if (clr_start) begin
						idx_q <= '0;
						fph_q <= '0;
						vph_q <= '0;
						for (int i = 0; i < MAXH; i++) begin
							hn_q[i] <= '0;
						end
					end
				end
				ahosc_pkg::ST_H_UPD: begin
					if (num_sum >= {1'b0, sr_eff}) begin
						hn_q[h_q] <= 17'(num_sum - {1'b0, sr_eff});
					end else begin
						hn_q[h_q] <= num_sum[16:0];
					end
				end
				ahosc_pkg::ST_V_FDIV_W: begin
					if (div_done) begin
						fph_q <= fneg_q ? fph_q - div_quot[PB-1:0] : fph_q + div_quot[PB-1:0];
					end
				end
				ahosc_pkg::ST_V_VDIV_W: begin
					if (div_done && cfg.vibrato_on) begin
						vph_q <= vph_q + div_quot[PB-1:0];
					end
				end
				ahosc_pkg::ST_WRAP: begin
					if (clr_wrap) begin
						idx_q <= '0;
						fph_q <= '0;
						vph_q <= '0;
						for (int i = 0; i < MAXH; i++) begin
							hn_q[i] <= '0;
						end
					end else begin
						idx_q <= idx_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// harmonic counter and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= '0;
			rst_req_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rst_req_q <= restart;
			end
			if (state_q == ahosc_pkg::ST_F_ACC) begin
				h_q <= '0;
			end else if (state_q == ahosc_pkg::ST_H_UPD && !last_h) begin
				h_q <= h_q + 1'b1;
			end
			if (state_q == ahosc_pkg::ST_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= 38'(mul_a) * 38'(mul_b);
		end
		case (state_q)
			ahosc_pkg::ST_F_MUL,
			ahosc_pkg::ST_H_MULW,
			ahosc_pkg::ST_V_MUL: begin
				sign_q <= rom_neg;
			end
			ahosc_pkg::ST_F_ACC: begin
				acc_q <= sign_q ? AW'(0) - fund_term : fund_term;
			end
			ahosc_pkg::ST_H_HF: begin
				active_q <= (hnum <= cfg.harmonic_count) &&
					({prod_q[18:0], 1'b0} < {3'd0, sr_eff});
			end
			ahosc_pkg::ST_H_HF_W: begin
				if (div_done) begin
					hfmod_q <= div_rem;
				end
			end
			ahosc_pkg::ST_H_PH_W: begin
				if (div_done) begin
					numrem_q <= div_mid;
					hph_q    <= div_quot[PB-1:0];
				end
			end
			ahosc_pkg::ST_H_HDIV_W: begin
				if (div_done) begin
					acc_q <= sign_q ? acc_q - harm_term : acc_q + harm_term;
				end
			end
			ahosc_pkg::ST_V_FREQ: begin
				fneg_q <= fneg;
			end
			default: begin
			end
		endcase
		// round half up to Q15 and saturate
		if (state_q == ahosc_pkg::ST_OUT && slot_free) begin
			if ($signed(res) > 22'sd32767) begin
				sample_q  <= 16'h7fff;
				clipped_q <= 1'b1;
			end else if ($signed(res) < -22'sd32768) begin
				sample_q  <= 16'h8000;
				clipped_q <= 1'b1;
			end else begin
				sample_q  <= res[15:0];
				clipped_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign clipped    = clipped_q;

	ahosc_div #(
		.PB  (PB),
		.DVW (DVW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem),
		.mid_rem   (div_mid)
	);

	ahosc_sine_rom #(
		.TB (TB)
	) u_rom (
		.clk       (clk),
		.rd_en     (rom_en),
		.phase_idx (rom_idx),
		.mag_q     (rom_mag),
		.neg_q     (rom_neg)
	);

`ifndef SYNTHESIS
	// an accepted word always starts with the clearing check
	a_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ahosc_pkg::ST_CLEAR)
		else $error("accepted word did not enter clear state");

	// the shared divider is never restarted mid-division
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// leaving the output state always presents a word
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ahosc_pkg::ST_OUT && slot_free |=>
			out_valid_q && state_q == ahosc_pkg::ST_IDLE)
		else $error("result word not loaded");
`endif

endmodule

### rtl/core/additive_harmonic_oscillator_core.sv
// ----------------------------------------------------------------------------
// additive_harmonic_oscillator_core
// Additive oscillator: fundamental plus weighted harmonics with vibrato.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / restart): each accepted word asks
//   for one audio sample; restart=1 clears the index and all phases first.
//   Output channel (out_valid / out_stall / sample_out / clipped): one word
//   per accepted input, signed Q1.15, clipped flags saturation.
//   The APB port writes and reads the eight settings at byte address 8*i.
// Timing:
//   With the default sizing, each of the eight harmonic slots costs two
//   passes of the shared bit-serial divider, three when that harmonic is in
//   use, and the phase increments two more passes.
//   in_stall is high from acceptance until the result is loaded into the
//   output register; one sample at a time is in flight.
// Reset:
//   Settings return to their defaults, index and phases clear, no output.
// Stalls:
//   A finished word waits in the output register while out_stall is high;
//   the next input is taken as soon as it is loaded.
// ----------------------------------------------------------------------------
module additive_harmonic_oscillator_core #(
	parameter int MAX_HARMONICS   = ahosc_pkg::MAX_HARMONICS,
	parameter int SINE_TABLE_BITS = ahosc_pkg::SINE_TABLE_BITS,
	parameter int PHASE_BITS      = ahosc_pkg::PHASE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	// output words
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample_out,
	output logic               clipped
);

	ahosc_pkg::cfg_t       cfg_q;
	ahosc_pkg::reg_idx_t   reg_sel;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_sel = ahosc_pkg::reg_idx_t'(paddr[5:3]);
	assign wr_en   = psel && penable && pwrite && pready;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_rate      <= ahosc_pkg::SAMPLE_RATE_RST;
			cfg_q.tone_frequency   <= ahosc_pkg::TONE_FREQ_RST;
			cfg_q.amplitude        <= ahosc_pkg::AMPLITUDE_RST;
			cfg_q.harmonic_count   <= '0;
			cfg_q.harmonic_weights <= '0;
			cfg_q.vibrato_on       <= 1'b0;
			cfg_q.vibrato_depth_hz <= '0;
			cfg_q.vibrato_rate_hz  <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				ahosc_pkg::REG_SAMPLE_RATE: cfg_q.sample_rate      <= pwdata[16:0];
				ahosc_pkg::REG_TONE_FREQ:   cfg_q.tone_frequency   <= pwdata[14:0];
				ahosc_pkg::REG_AMPLITUDE:   cfg_q.amplitude        <= pwdata[14:0];
				ahosc_pkg::REG_HARM_COUNT:  cfg_q.harmonic_count   <= pwdata[3:0];
				ahosc_pkg::REG_HARM_WEIGHT: cfg_q.harmonic_weights <= pwdata;
				ahosc_pkg::REG_VIB_ON:      cfg_q.vibrato_on       <= pwdata[0];
				ahosc_pkg::REG_VIB_DEPTH:   cfg_q.vibrato_depth_hz <= pwdata[9:0];
				ahosc_pkg::REG_VIB_RATE:    cfg_q.vibrato_rate_hz  <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			ahosc_pkg::REG_SAMPLE_RATE: prdata = 64'(cfg_q.sample_rate);
			ahosc_pkg::REG_TONE_FREQ:   prdata = 64'(cfg_q.tone_frequency);
			ahosc_pkg::REG_AMPLITUDE:   prdata = 64'(cfg_q.amplitude);
			ahosc_pkg::REG_HARM_COUNT:  prdata = 64'(cfg_q.harmonic_count);
			ahosc_pkg::REG_HARM_WEIGHT: prdata = cfg_q.harmonic_weights;
			ahosc_pkg::REG_VIB_ON:      prdata = 64'(cfg_q.vibrato_on);
			ahosc_pkg::REG_VIB_DEPTH:   prdata = 64'(cfg_q.vibrato_depth_hz);
			ahosc_pkg::REG_VIB_RATE:    prdata = 64'(cfg_q.vibrato_rate_hz);
			default: prdata = '0;
		endcase
	end

	ahosc_engine #(
		.MAXH (MAX_HARMONICS),
		.TB   (SINE_TABLE_BITS),
		.PB   (PHASE_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

endmodule
